// ===== src/hps_pkg.sv =====
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants for the heap sorter cell chain.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int DATA_W            = 32;
  localparam int DEFAULT_MAX_ITEMS = 64;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } hps_state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic load;   // insert the incoming value into the chain
    logic shift;  // move every entry one cell toward the head
    logic desc;   // descending order: larger values go first
  } hps_ctrl_t;

endpackage

// ===== src/hps_cell.sv =====
// ----------------------------------------------------------------------------
// hps_cell
// One cell of the sorting chain: holds one value and its valid bit.
// ----------------------------------------------------------------------------
module hps_cell
  import hps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  hps_ctrl_t                ctrl,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic                     prev_ins,
  input  logic                     prev_valid,
  input  logic signed [DATA_W-1:0] prev_value,
  input  logic                     next_valid,
  input  logic signed [DATA_W-1:0] next_value,
  output logic                     ins,
  output logic                     valid,
  output logic signed [DATA_W-1:0] value
);

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;
  logic                     new_first;

  // strict compare keeps equal values in arrival order
  assign new_first = ctrl.desc ? (new_value > value_r) : (new_value < value_r);
  assign ins       = !valid_r || new_first;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.shift) begin
      valid_nxt = next_valid;
      value_nxt = next_value;
    end else if (ctrl.load && ins) begin
      // cells past the insertion point take their left neighbor's entry
      valid_nxt = prev_ins ? prev_valid : 1'b1;
      value_nxt = prev_ins ? prev_value : new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;

endmodule

// ===== src/heap_sorter.sv =====
// ----------------------------------------------------------------------------
// heap_sorter
// Collects a set of signed values and returns them in sorted order.
// ----------------------------------------------------------------------------
// A set loads at one input transaction per cycle into a chain of MAX_ITEMS
// cells that keeps it sorted as each value arrives (one compare per cell,
// all cells in parallel). The transaction marked last ends the set; from the
// next cycle the block delivers the N held values one per cycle while
// out_ready is high, head cell first, and accepts no input until the final
// result (last_out) is taken. Values beyond MAX_ITEMS are dropped and
// items_dropped is set on every result of that set. cfg_descending_order
// selects descending order; the user must write it only while no set is in
// progress, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module heap_sorter
  import hps_pkg::*;
#(
  parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_descending_order,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_data_value,
  input  logic                     in_last_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic                     out_last_out,
  output logic                     out_items_dropped
);

  hps_state_t st_r, st_nxt;
  logic       desc_r;
  logic       overflow_r, overflow_nxt;
  hps_ctrl_t  ctrl;
  logic       in_acc, out_acc, full;

  logic [MAX_ITEMS-1:0]     cell_valid;
  logic [MAX_ITEMS-1:0]     cell_ins;
  logic signed [DATA_W-1:0] cell_value [MAX_ITEMS];

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign full      = cell_valid[MAX_ITEMS-1];

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_LOAD:  if (in_acc && in_last_item) st_nxt = ST_DRAIN;
      ST_DRAIN: if (out_acc && out_last_out) st_nxt = ST_LOAD;
      default:  st_nxt = ST_LOAD;
    endcase
  end

  // outputs and chain control
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.shift = 1'b0;
    ctrl.desc  = desc_r;
    unique case (st_r)
      ST_LOAD: begin
        in_ready  = 1'b1;
        ctrl.load = in_acc && !full;
      end
      ST_DRAIN: begin
        out_valid  = cell_valid[0];
        ctrl.shift = out_acc;
      end
      default: ;
    endcase
  end

  assign out_sorted_value  = cell_value[0];
  assign out_last_out      = !cell_valid[1];
  assign out_items_dropped = overflow_r;

  always_comb begin
    overflow_nxt = overflow_r;
    if (in_acc && full) overflow_nxt = 1'b1;
    else if (out_acc && out_last_out) overflow_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_LOAD;
      desc_r     <= 1'b0;
      overflow_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      overflow_r <= overflow_nxt;
      if (cfg_valid && cfg_ready) desc_r <= cfg_descending_order;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                     p_ins;
    logic                     p_valid;
    logic signed [DATA_W-1:0] p_value;
    logic                     n_valid;
    logic signed [DATA_W-1:0] n_value;

    if (i == 0) begin : g_head
      assign p_ins   = 1'b0;
      assign p_valid = 1'b0;
      assign p_value = in_data_value;
    end else begin : g_mid
      assign p_ins   = cell_ins[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_value = cell_value[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_value = cell_value[i];
    end else begin : g_body
      assign n_valid = cell_valid[i+1];
      assign n_value = cell_value[i+1];
    end

    hps_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_value  (in_data_value),
      .prev_ins   (p_ins),
      .prev_valid (p_valid),
      .prev_value (p_value),
      .next_valid (n_valid),
      .next_value (n_value),
      .ins        (cell_ins[i]),
      .valid      (cell_valid[i]),
      .value      (cell_value[i])
    );
  end

  // occupied cells always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid & (cell_valid + 1'b1)) == '0))
    else $error("cell chain has a hole");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DRAIN) |-> cell_valid[0])
    else $error("drain with empty chain");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_last_out) |=>
      (desc_r ? !(out_sorted_value > $past(out_sorted_value))
              : !(out_sorted_value < $past(out_sorted_value))))
    else $error("results out of order");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |=> out_items_dropped)
    else $error("dropped value not flagged");

endmodule
